// ===== design/bfia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfia_pkg
// shared types and constants of the best fit interval allocator
// ----------------------------------------------------------------------------
package bfia_pkg;
  localparam int MAX_INTERVALS = 16;
  localparam int IDX_BITS = $clog2(MAX_INTERVALS);
  localparam int CNT_BITS = $clog2(MAX_INTERVALS + 1);
  localparam logic [31:0] HEAP_RESET = 32'd65536;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_MAX,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic scan_step;
    logic apply;
    logic max_step;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;
endpackage

// ===== design/bfia_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfia_req_if / bfia_rsp_if
// request and result channels of the allocator
// ----------------------------------------------------------------------------
interface bfia_req_if;
  logic valid;
  logic ready;
  logic operation;
  logic [31:0] request_size;
  logic [31:0] release_start;
  modport source (output valid, operation, request_size, release_start, input ready);
  modport sink (input valid, operation, request_size, release_start, output ready);
endinterface

interface bfia_rsp_if;
  logic valid;
  logic ready;
  logic [31:0] block_start;
  logic [1:0] status;
  logic [31:0] largest_free;
  modport source (output valid, block_start, status, largest_free, input ready);
  modport sink (input valid, block_start, status, largest_free, output ready);
endinterface

// ===== design/bfia_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfia_ctrl
// sequencer: scan, apply, max sweep, output hold
// ----------------------------------------------------------------------------
module bfia_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  bfia_pkg::sts_t  sts,
  output bfia_pkg::cmd_t  cmd
);
  import bfia_pkg::*;
  state_t state_r, state_nxt;
  logic loaded_r, loaded_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      loaded_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      loaded_r <= loaded_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    loaded_nxt = loaded_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.load = !loaded_r;
          loaded_nxt = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.last) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_MAX;
      end
      S_MAX: begin
        cmd.max_step = 1'b1;
        if (sts.last) state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== design/bfia_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfia_dp
// interval table, one entry a cycle scan, update and max sweep
// ----------------------------------------------------------------------------
module bfia_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  bfia_pkg::cmd_t      cmd,
  output bfia_pkg::sts_t      sts,
  input  logic [31:0]         heap_size,
  input  logic                operation,
  input  logic [31:0]         request_size,
  input  logic [31:0]         release_start,
  output logic [31:0]         block_start,
  output logic [1:0]          status,
  output logic [31:0]         largest_free
);
  import bfia_pkg::*;
  logic [31:0] fs_r [MAX_INTERVALS];
  logic [31:0] fz_r [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] fv_r;
  logic op_r;
  logic [31:0] n_r, s_r;
  logic [IDX_BITS-1:0] i_r;
  logic pf_r, lf_r, rf_r, ef_r;
  logic [IDX_BITS-1:0] pk_r, lt_r, rt_r, em_r;
  logic [31:0] best_r, bs_r, maxv_r, res_start_r;
  logic [1:0] res_st_r;
  logic [32:0] end_w, ent_end;
  logic [31:0] cs, cz;
  logic cv, ign;
  logic [32:0] sum_l, sum_r, sum_lr;

  assign cs = fs_r[i_r];
  assign cz = fz_r[i_r];
  assign cv = fv_r[i_r];
  assign end_w = {1'b0, s_r} + {1'b0, n_r};
  assign ent_end = {1'b0, cs} + {1'b0, cz};
  assign ign = (n_r == '0) || (end_w > 33'h1_0000_0000);
  assign sts.last = (i_r == IDX_BITS'(MAX_INTERVALS - 1));
  assign sum_l = {1'b0, fz_r[lt_r]} + {1'b0, n_r};
  assign sum_r = {1'b0, fz_r[rt_r]} + {1'b0, n_r};
  assign sum_lr = sum_l + {1'b0, fz_r[rt_r]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
      i_r <= '0;
    end else begin
      if (cmd.capture) begin
        op_r <= operation;
        n_r <= request_size;
        s_r <= release_start;
        i_r <= '0;
        pf_r <= 1'b0; lf_r <= 1'b0; rf_r <= 1'b0; ef_r <= 1'b0;
        maxv_r <= '0;
        if (cmd.load && heap_size != '0) begin
          fs_r[0] <= '0;
          fz_r[0] <= heap_size;
          fv_r[0] <= 1'b1;
        end
      end
      if (cmd.scan_step) begin
        i_r <= i_r + 1'b1;
        if (cv) begin
          if (cz >= n_r && (!pf_r || cz < best_r || (cz == best_r && cs < bs_r))) begin
            pf_r <= 1'b1; pk_r <= i_r; best_r <= cz; bs_r <= cs;
          end
          if (!lf_r && ent_end == {1'b0, s_r}) begin
            lf_r <= 1'b1; lt_r <= i_r;
          end
          if (!rf_r && {1'b0, cs} == end_w) begin
            rf_r <= 1'b1; rt_r <= i_r;
          end
        end else if (!ef_r) begin
          ef_r <= 1'b1; em_r <= i_r;
        end
      end
      if (cmd.apply) begin
        res_start_r <= '0;
        res_st_r <= ST_OK;
        if (!op_r) begin
          if (!pf_r) res_st_r <= ST_NO_SPACE;
          else begin
            res_start_r <= bs_r;
            if (best_r == n_r) fv_r[pk_r] <= 1'b0;
            else begin
              fs_r[pk_r] <= bs_r + n_r;
              fz_r[pk_r] <= best_r - n_r;
            end
          end
        end else if (!ign) begin
          if (lf_r && !sum_l[32]) begin
            if (rf_r && rt_r != lt_r && !sum_lr[32]) begin
              fz_r[lt_r] <= sum_lr[31:0];
              fv_r[rt_r] <= 1'b0;
            end else fz_r[lt_r] <= sum_l[31:0];
          end else if (rf_r && !sum_r[32]) begin
            fs_r[rt_r] <= s_r;
            fz_r[rt_r] <= sum_r[31:0];
          end else if (ef_r) begin
            fs_r[em_r] <= s_r;
            fz_r[em_r] <= n_r;
            fv_r[em_r] <= 1'b1;
          end else res_st_r <= ST_FULL;
        end
      end
      if (cmd.max_step) begin
        i_r <= i_r + 1'b1;
        if (cv && cz > maxv_r) maxv_r <= cz;
      end
    end
  end

  assign block_start = res_start_r;
  assign status = res_st_r;
  assign largest_free = maxv_r;
endmodule

// ===== design/best_fit_interval_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_interval_allocator_unit
// best fit heap interval allocator with coalescing release
// ----------------------------------------------------------------------------
// in channel: one word per request (operation, request_size, release_start);
//   operation 0 allocates, 1 releases.
// out channel: one word per request (block_start, status, largest_free).
// cfg port: cfg_we / cfg_wdata write heap_size, read when the table loads on
//   the first request after reset.
// after accept: one table entry a cycle for the fit/neighbor scan, then the
//   table update, then one entry a cycle for the largest free sweep.
// a new request is taken only once the last result has been taken;
//   in_ready is high only when idle.
// the result holds on the out port until taken; a stalled receiver holds
//   off the next request.
// reset (rst_n low, synchronous) empties the table and restores heap_size
//   to 65536.
// ----------------------------------------------------------------------------
module best_fit_interval_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  bfia_req_if.sink    in_ch,
  bfia_rsp_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import bfia_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic [31:0] heap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) heap_r <= HEAP_RESET;
    else if (cfg_we) heap_r <= cfg_wdata;
  end

  bfia_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  bfia_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .heap_size(heap_r),
    .operation(in_ch.operation), .request_size(in_ch.request_size),
    .release_start(in_ch.release_start),
    .block_start(out_ch.block_start), .status(out_ch.status),
    .largest_free(out_ch.largest_free)
  );

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status != 2'd3)) else $error("bad status");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.block_start == '0)
    else $error("start on failure");
endmodule

// ===== dv/best_fit_interval_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_interval_allocator_unit_tb
// Self-checking bench for the best fit interval allocator. A predictor keeps
// its own copy of the free interval table and computes the expected result
// word of every accepted request. A checker compares each result word field
// by field with the oldest expected one. Stimulus has a directed part for
// the special cases and then random allocate and release words. Both sides
// idle in random bursts, with one long receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------
module best_fit_interval_allocator_unit_tb;
  import bfia_pkg::*;

  typedef struct {
    logic [31:0] block_start;
    status_t     status;
    logic [31:0] largest_free;
  } rsp_word_t;

  typedef struct {
    logic [31:0] start;
    logic [31:0] size;
  } blk_t;

  localparam logic [32:0] ADDR_LIMIT = 33'h1_0000_0000;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  bfia_req_if in_if ();
  bfia_rsp_if out_if ();

  best_fit_interval_allocator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predicted allocator state
  logic [31:0] tbl_start [MAX_INTERVALS];
  logic [31:0] tbl_size [MAX_INTERVALS];
  bit          tbl_valid [MAX_INTERVALS];
  bit          tbl_loaded;
  logic [31:0] heap_reg;

  rsp_word_t expected_words[$];
  blk_t      live_blocks[$];

  int errors;
  int sent_count;
  int checked_count;
  int full_count;
  int nospace_count;
  int idle_cycles;
  bit quiet;
  int hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] largest_interval();
    logic [31:0] best;
    best = 32'd0;
    for (int i = 0; i < MAX_INTERVALS; i++)
      if (tbl_valid[i] && tbl_size[i] > best) best = tbl_size[i];
    return best;
  endfunction

  function automatic void predict_word(input logic op, input logic [31:0] n,
                                       input logic [31:0] s);
    rsp_word_t w;
    blk_t nb;
    int pick;
    int left;
    int right;
    int host;
    logic [32:0] stop;
    w.block_start = 32'd0;
    w.status = ST_OK;
    if (!tbl_loaded) begin
      for (int i = 0; i < MAX_INTERVALS; i++) tbl_valid[i] = 1'b0;
      if (heap_reg != 32'd0) begin
        tbl_start[0] = 32'd0;
        tbl_size[0] = heap_reg;
        tbl_valid[0] = 1'b1;
      end
      tbl_loaded = 1'b1;
    end
    if (op == 1'b0) begin
      pick = -1;
      for (int i = 0; i < MAX_INTERVALS; i++) begin
        if (!tbl_valid[i] || tbl_size[i] < n) continue;
        if (pick < 0 || tbl_size[i] < tbl_size[pick] ||
            (tbl_size[i] == tbl_size[pick] && tbl_start[i] < tbl_start[pick]))
          pick = i;
      end
      if (pick < 0) begin
        w.status = ST_NO_SPACE;
      end else begin
        w.block_start = tbl_start[pick];
        if (tbl_size[pick] == n) begin
          tbl_valid[pick] = 1'b0;
        end else begin
          tbl_start[pick] = tbl_start[pick] + n;
          tbl_size[pick] = tbl_size[pick] - n;
        end
      end
    end else begin
      stop = {1'b0, s} + {1'b0, n};
      if (n != 32'd0 && stop <= ADDR_LIMIT) begin
        left = -1;
        right = -1;
        host = -1;
        for (int i = 0; i < MAX_INTERVALS; i++) begin
          if (!tbl_valid[i]) continue;
          if (left < 0 && {1'b0, tbl_start[i]} + {1'b0, tbl_size[i]} == {1'b0, s})
            left = i;
          if (right < 0 && {1'b0, tbl_start[i]} == stop) right = i;
        end
        if (left >= 0 && {1'b0, tbl_size[left]} + {1'b0, n} <= 33'hFFFF_FFFF) begin
          tbl_size[left] = tbl_size[left] + n;
          host = left;
        end
        if (right >= 0 && right != host) begin
          if (host >= 0) begin
            if ({1'b0, tbl_size[host]} + {1'b0, tbl_size[right]} <= 33'hFFFF_FFFF) begin
              tbl_size[host] = tbl_size[host] + tbl_size[right];
              tbl_valid[right] = 1'b0;
            end
          end else if ({1'b0, tbl_size[right]} + {1'b0, n} <= 33'hFFFF_FFFF) begin
            tbl_start[right] = s;
            tbl_size[right] = tbl_size[right] + n;
            host = right;
          end
        end
        if (host < 0) begin
          w.status = ST_FULL;
          for (int i = 0; i < MAX_INTERVALS; i++) begin
            if (!tbl_valid[i]) begin
              tbl_start[i] = s;
              tbl_size[i] = n;
              tbl_valid[i] = 1'b1;
              w.status = ST_OK;
              break;
            end
          end
        end
      end
    end
    w.largest_free = largest_interval();
    if (w.status == ST_FULL) full_count++;
    if (w.status == ST_NO_SPACE) nospace_count++;
    if (op == 1'b0 && w.status == ST_OK && n != 32'd0) begin
      nb.start = w.block_start;
      nb.size = n;
      live_blocks = {live_blocks, nb};
    end
    expected_words = {expected_words, w};
  endfunction

  // sends one request word; valid stays high when no gap follows
  task automatic send_word(input logic op, input logic [31:0] n, input logic [31:0] s);
    int gap;
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.request_size <= n;
    in_if.release_start <= s;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    predict_word(op, n, s);
    sent_count++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (2 * MAX_INTERVALS + 8) @(posedge clk);
  endtask

  task automatic write_heap_size(input logic [31:0] value);
    in_if.valid <= 1'b0;
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    heap_reg = value;
  endtask

  // result side: random stall bursts, plus a long hold when asked
  initial begin
    int stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk) begin
    rsp_word_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word start=%h status=%0d largest=%h", $time,
                 out_if.block_start, out_if.status, out_if.largest_free);
        errors++;
      end else begin
        w = expected_words.pop_front();
        checked_count++;
        if (out_if.block_start !== w.block_start) begin
          $display("%0t: block_start expected %h actual %h", $time,
                   w.block_start, out_if.block_start);
          errors++;
        end
        if (out_if.status !== w.status) begin
          $display("%0t: status expected %0d actual %0d", $time, w.status, out_if.status);
          errors++;
        end
        if (out_if.largest_free !== w.largest_free) begin
          $display("%0t: largest_free expected %h actual %h", $time,
                   w.largest_free, out_if.largest_free);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d words outstanding", $time,
               expected_words.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic release_live(input int idx);
    blk_t b;
    b = live_blocks[idx];
    live_blocks.delete(idx);
    send_word(1'b1, b.size, b.start);
  endtask

  task automatic test_directed();
    int i;
    send_word(1'b0, 32'd0, 32'hFFFF_FFFF);
    send_word(1'b0, 32'd100, 32'd0);
    send_word(1'b0, 32'd4097, 32'd0);
    send_word(1'b0, 32'hFFFF_FFFF, 32'd0);
    send_word(1'b1, 32'd0, 32'd0);
    send_word(1'b1, 32'd2, 32'hFFFF_FFFF);
    send_word(1'b1, 32'd1, 32'hFFFF_FFFF);
    live_blocks.delete();
    send_word(1'b1, 32'd100, 32'd0);
    send_word(1'b0, 32'd4096, 32'd0);
    send_word(1'b1, 32'd4096, 32'd0);
    send_word(1'b1, 32'hFFFF_EFFF, 32'd4096);
    send_word(1'b0, 32'hFFFF_FFFF, 32'd0);
    send_word(1'b1, 32'd5, 32'd10);
    send_word(1'b1, 32'd5, 32'd10);
    i = 0;
    while (full_count == 0 && i < 20) begin
      send_word(1'b1, 32'd5, 32'd1000 + 32'd20 * i);
      i++;
    end
    send_word(1'b0, 32'd5, 32'd0);
    send_word(1'b0, 32'd0, 32'd0);
  endtask

  task automatic random_word();
    int pick;
    logic [31:0] n;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      n = (pick < 3) ? $urandom() : ((pick < 5) ? 32'd0 : $urandom_range(1, 400));
      send_word(1'b0, n, $urandom());
    end else if (pick < 85 && live_blocks.size() != 0) begin
      release_live($urandom_range(0, live_blocks.size() - 1));
    end else if (pick < 90) begin
      send_word(1'b1, $urandom(), $urandom());
    end else if (pick < 95) begin
      send_word(1'b1, $urandom_range(1, 64), $urandom_range(0, 32'h0002_0000));
    end else begin
      send_word(1'b1, $urandom_range(0, 3) == 0 ? 32'd0 : 32'd16, 32'hFFFF_FFF8);
    end
  endtask

  task automatic test_random(input int count);
    send_word(1'b1, 32'd8192, 32'h0001_0000);
    repeat (count) random_word();
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    repeat (30) random_word();
  endtask

  task automatic test_drain_pause();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) random_word();
  endtask

  task automatic test_late_config();
    write_heap_size(32'd0);
    repeat (60) random_word();
    write_heap_size(32'hFFFF_FFFF);
    repeat (60) random_word();
    write_heap_size(32'd1);
  endtask

  initial begin
    errors = 0;
    sent_count = 0;
    checked_count = 0;
    full_count = 0;
    nospace_count = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    hold_off = 0;
    heap_reg = HEAP_RESET;
    tbl_loaded = 1'b0;
    for (int i = 0; i < MAX_INTERVALS; i++) tbl_valid[i] = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 32'd0;
    in_if.valid = 1'b0;
    in_if.operation = 1'b0;
    in_if.request_size = 32'd0;
    in_if.release_start = 32'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // only the last write before the first word sets the heap
    write_heap_size(32'hFFFF_FFFF);
    write_heap_size(32'd4096);
    test_directed();
    test_random(500);
    test_backpressure();
    test_drain_pause();
    test_late_config();
    quiet = 1'b1;
    test_random(200);
    in_if.valid <= 1'b0;
    wait_drained();
    $display("sent %0d request words, checked %0d results", sent_count, checked_count);
    $display("table full seen %0d times, no space seen %0d times", full_count, nospace_count);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

// ===== best_fit_interval_allocator_unit.f =====
design/bfia_pkg.sv
design/bfia_if.sv
design/bfia_ctrl.sv
design/bfia_dp.sv
design/best_fit_interval_allocator_unit.sv
dv/best_fit_interval_allocator_unit_tb.sv
